// File: hw/rtl/bsdf_pkg.sv
// ----------------------------------------------------------------------------
// bsdf_pkg
// Shared types and constants of the batch-SMTP data deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package bsdf_pkg;

    localparam int unsigned LEN_W          = 24;
    localparam int unsigned COUNT_BITS_DEF = 24;
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 24'd256000;

    // Up to four results leave the block for one input byte.
    localparam int unsigned MAX_RES   = 4;
    localparam int unsigned RES_CNT_W = 3;
    localparam int unsigned RES_IDX_W = 2;

    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_DOT  = 8'h2E;
    localparam logic [7:0] CH_CASE = 8'h20;
    localparam logic [7:0] CH_D_LC = 8'h64;
    localparam logic [7:0] CH_A_LC = 8'h61;
    localparam logic [7:0] CH_T_LC = 8'h74;

    localparam logic [1:0] PH_ENV   = 2'd0;
    localparam logic [1:0] PH_BODY  = 2'd1;
    localparam logic [1:0] PH_TRAIL = 2'd2;
    localparam logic [1:0] PH_OVER  = 2'd3;

    localparam logic [2:0] KP_NONE   = 3'd0;
    localparam logic [2:0] KP_LF     = 3'd1;
    localparam logic [2:0] KP_D      = 3'd2;
    localparam logic [2:0] KP_DA     = 3'd3;
    localparam logic [2:0] KP_DAT    = 3'd4;
    localparam logic [2:0] KP_DATA   = 3'd5;
    localparam logic [2:0] KP_DATACR = 3'd6;

    localparam logic [1:0] BS_START = 2'd0;
    localparam logic [1:0] BS_MID   = 2'd1;
    localparam logic [1:0] BS_DOT   = 2'd2;
    localparam logic [1:0] BS_DOTCR = 2'd3;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_DATA = 2'd1;
    localparam logic [1:0] ST_TOO_BIG = 2'd2;

    typedef struct packed {
        logic       kind;
        logic [7:0] out_byte;
        logic [1:0] region;
        logic [1:0] status;
    } res_t;

    typedef struct packed {
        logic [RES_CNT_W-1:0] cnt;
        res_t [MAX_RES-1:0]   res;
    } grp_t;

endpackage

`default_nettype wire

// File: hw/rtl/bsdf_if.sv
// ----------------------------------------------------------------------------
// bsdf_if
// Valid/ready channels of the deframer: byte input, results, configuration.
// ----------------------------------------------------------------------------
`default_nettype none

interface bsdf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface bsdf_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] out_byte;
    logic [1:0] region;
    logic [1:0] status;
    logic       end_of_run;

    modport source (output valid, output kind, output out_byte, output region,
                    output status, output end_of_run, input ready);
    modport sink (input valid, input kind, input out_byte, input region,
                  input status, input end_of_run, output ready);
endinterface

interface bsdf_cfg_if;
    logic        valid;
    logic        ready;
    logic [23:0] max_length;

    modport source (output valid, output max_length, input ready);
    modport sink (input valid, input max_length, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/bsdf_core.sv
// ----------------------------------------------------------------------------
// bsdf_core
// Stream state machine: tags, unstuffs and counts one byte per accepted word
// and forms the group of results that byte causes.
// ----------------------------------------------------------------------------
`default_nettype none

module bsdf_core #(
    parameter int unsigned COUNT_BITS = bsdf_pkg::COUNT_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [bsdf_pkg::LEN_W-1:0] max_length,
    input  logic                       step,
    input  logic [7:0]                 data_byte,
    input  logic                       last_byte,
    output bsdf_pkg::grp_t             grp
);
    import bsdf_pkg::*;

    localparam int unsigned CMP_W = (COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W;

    logic [1:0]            phase_reg, phase_next;
    logic [2:0]            kp_reg, kp_next;
    logic [1:0]            bs_reg, bs_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;

    function automatic res_t mk(input logic k, input logic [7:0] b,
                                input logic [1:0] rg, input logic [1:0] st);
        res_t r;
        r.kind     = k;
        r.out_byte = b;
        r.region   = rg;
        r.status   = st;
        return r;
    endfunction

    always_comb
    begin
        logic [RES_CNT_W-1:0] n;
        res_t [MAX_RES-1:0]   res;
        logic [1:0]           ph;
        logic [2:0]           kp;
        logic [1:0]           bs;
        logic [1:0]           bs_eol;
        logic [1:0]           st;
        logic [7:0]           lc;

        ph     = phase_reg;
        kp     = kp_reg;
        bs     = bs_reg;
        n      = '0;
        res    = '0;
        st     = ST_OK;
        lc     = data_byte | CH_CASE;
        bs_eol = (data_byte == CH_LF) ? BS_START : BS_MID;
        count_next = count_reg;

        // Size check comes first; bytes held at a line start are let go as
        // oversize ahead of the byte that crosses the limit.
        if (ph != PH_OVER)
        begin
            if (CMP_W'(count_reg) >= CMP_W'(max_length))
            begin
                if (ph == PH_BODY)
                begin
                    if (bs == BS_DOT || bs == BS_DOTCR)
                    begin
                        res[n[RES_IDX_W-1:0]] = mk(KIND_DATA, CH_DOT, PH_OVER, ST_OK);
                        n = n + 3'd1;
                    end
                    if (bs == BS_DOTCR)
                    begin
                        res[n[RES_IDX_W-1:0]] = mk(KIND_DATA, CH_CR, PH_OVER, ST_OK);
                        n = n + 3'd1;
                    end
                    bs = BS_MID;
                end
                ph = PH_OVER;
            end
            else if (count_reg != '1)
            begin
                count_next = count_reg + 1'b1;
            end
        end

        unique case (ph)
            PH_ENV:
            begin
                res[n[RES_IDX_W-1:0]] = mk(KIND_DATA, data_byte, PH_ENV, ST_OK);
                n = n + 3'd1;
                if ((kp == KP_DATA || kp == KP_DATACR) && data_byte == CH_LF)
                begin
                    ph = PH_BODY;
                    bs = BS_START;
                    kp = KP_NONE;
                end
                else
                begin
                    priority if (kp == KP_DATA && data_byte == CH_CR)
                        kp = KP_DATACR;
                    else if (data_byte == CH_LF)
                        kp = KP_LF;
                    else if (kp == KP_LF && lc == CH_D_LC)
                        kp = KP_D;
                    else if (kp == KP_D && lc == CH_A_LC)
                        kp = KP_DA;
                    else if (kp == KP_DA && lc == CH_T_LC)
                        kp = KP_DAT;
                    else if (kp == KP_DAT && lc == CH_A_LC)
                        kp = KP_DATA;
                    else
                        kp = KP_NONE;
                end
            end
            PH_BODY:
            begin
                unique case (bs)
                    BS_START:
                    begin
                        if (data_byte == CH_DOT)
                        begin
                            bs = BS_DOT;
                        end
                        else
                        begin
                            res[n[RES_IDX_W-1:0]] = mk(KIND_DATA, data_byte, PH_BODY, ST_OK);
                            n  = n + 3'd1;
                            bs = bs_eol;
                        end
                    end
                    BS_DOT:
                    begin
                        priority if (data_byte == CH_LF)
                        begin
                            res[n[RES_IDX_W-1:0]] = mk(KIND_DATA, CH_DOT, PH_TRAIL, ST_OK);
                            n = n + 3'd1;
                            res[n[RES_IDX_W-1:0]] = mk(KIND_DATA, data_byte, PH_TRAIL, ST_OK);
                            n  = n + 3'd1;
                            ph = PH_TRAIL;
                            bs = BS_MID;
                        end
                        else if (data_byte == CH_CR)
                        begin
                            bs = BS_DOTCR;
                        end
                        else if (data_byte == CH_DOT)
                        begin
                            // Doubled dot: one of the two is dropped.
                            res[n[RES_IDX_W-1:0]] = mk(KIND_DATA, CH_DOT, PH_BODY, ST_OK);
                            n  = n + 3'd1;
                            bs = BS_MID;
                        end
                        else
                        begin
                            res[n[RES_IDX_W-1:0]] = mk(KIND_DATA, CH_DOT, PH_BODY, ST_OK);
                            n = n + 3'd1;
                            res[n[RES_IDX_W-1:0]] = mk(KIND_DATA, data_byte, PH_BODY, ST_OK);
                            n  = n + 3'd1;
                            bs = BS_MID;
                        end
                    end
                    BS_DOTCR:
                    begin
                        if (data_byte == CH_LF)
                        begin
                            res[n[RES_IDX_W-1:0]] = mk(KIND_DATA, CH_DOT, PH_TRAIL, ST_OK);
                            n = n + 3'd1;
                            res[n[RES_IDX_W-1:0]] = mk(KIND_DATA, CH_CR, PH_TRAIL, ST_OK);
                            n = n + 3'd1;
                            res[n[RES_IDX_W-1:0]] = mk(KIND_DATA, data_byte, PH_TRAIL, ST_OK);
                            n  = n + 3'd1;
                            ph = PH_TRAIL;
                            bs = BS_MID;
                        end
                        else
                        begin
                            res[n[RES_IDX_W-1:0]] = mk(KIND_DATA, CH_DOT, PH_BODY, ST_OK);
                            n = n + 3'd1;
                            res[n[RES_IDX_W-1:0]] = mk(KIND_DATA, CH_CR, PH_BODY, ST_OK);
                            n = n + 3'd1;
                            res[n[RES_IDX_W-1:0]] = mk(KIND_DATA, data_byte, PH_BODY, ST_OK);
                            n  = n + 3'd1;
                            bs = bs_eol;
                        end
                    end
                    BS_MID:
                    begin
                        res[n[RES_IDX_W-1:0]] = mk(KIND_DATA, data_byte, PH_BODY, ST_OK);
                        n  = n + 3'd1;
                        bs = bs_eol;
                    end
                endcase
            end
            PH_TRAIL:
            begin
                res[n[RES_IDX_W-1:0]] = mk(KIND_DATA, data_byte, PH_TRAIL, ST_OK);
                n = n + 3'd1;
            end
            PH_OVER:
            begin
                res[n[RES_IDX_W-1:0]] = mk(KIND_DATA, data_byte, PH_OVER, ST_OK);
                n = n + 3'd1;
            end
        endcase

        if (last_byte)
        begin
            // A dot still held at end of stream was never part of a full
            // terminator line, so it goes out as body.
            if (ph == PH_BODY)
            begin
                if (bs == BS_DOT || bs == BS_DOTCR)
                begin
                    res[n[RES_IDX_W-1:0]] = mk(KIND_DATA, CH_DOT, PH_BODY, ST_OK);
                    n = n + 3'd1;
                end
                if (bs == BS_DOTCR)
                begin
                    res[n[RES_IDX_W-1:0]] = mk(KIND_DATA, CH_CR, PH_BODY, ST_OK);
                    n = n + 3'd1;
                end
            end
            priority if (ph == PH_OVER)
                st = ST_TOO_BIG;
            else if (ph == PH_ENV)
                st = ST_NO_DATA;
            else
                st = ST_OK;
            res[n[RES_IDX_W-1:0]] = mk(KIND_STATUS, 8'h00, ph, st);
            n = n + 3'd1;
            ph         = PH_ENV;
            kp         = KP_NONE;
            bs         = BS_START;
            count_next = '0;
        end

        phase_next = ph;
        kp_next    = kp;
        bs_next    = bs;
        grp.cnt    = n;
        grp.res    = res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_ENV;
            kp_reg    <= KP_NONE;
            bs_reg    <= BS_START;
            count_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            kp_reg    <= kp_next;
            bs_reg    <= bs_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/bsdf_outq.sv
// ----------------------------------------------------------------------------
// bsdf_outq
// Result register: holds the group of one byte and hands it out one word
// per cycle while head_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module bsdf_outq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  bsdf_pkg::grp_t grp_in,
    output logic           can_load,
    output logic           head_valid,
    input  logic           head_ready,
    output bsdf_pkg::res_t head,
    output logic           head_last
);
    import bsdf_pkg::*;

    grp_t                 grp_reg;
    logic [RES_CNT_W-1:0] left_reg;
    logic [RES_IDX_W-1:0] idx_reg;

    assign head_valid = (left_reg != '0);
    assign head_last  = (left_reg == RES_CNT_W'(1));
    assign head       = grp_reg.res[idx_reg];
    // A new group may land as the final word of the current one leaves.
    assign can_load   = (left_reg == '0) || (head_last && head_ready);

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            grp_reg <= grp_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
            idx_reg  <= '0;
        end
        else if (load)
        begin
            left_reg <= grp_in.cnt;
            idx_reg  <= '0;
        end
        else if (head_valid && head_ready)
        begin
            left_reg <= left_reg - RES_CNT_W'(1);
            idx_reg  <= idx_reg + RES_IDX_W'(1);
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/bsmtp_data_deframer_top.sv
// ----------------------------------------------------------------------------
// bsmtp_data_deframer_top
// Batch-SMTP deframer: tags envelope, body and trailer bytes and removes the
// stuffed dot at body line starts.
// ----------------------------------------------------------------------------
//  Channel  Dir  Word contents
//  stream   in   data_byte, last_byte
//  result   out  kind, out_byte, region, status, end_of_run
//  cfg      in   max_length (always ready)
//
//  Each accepted byte's zero to four results are registered and leave one per
//  cycle while result is ready, so the rate is one byte per cycle while each
//  byte gives at most one result, else one byte per result word.
//  The result register is the only limit: a new byte is taken while the last
//  word of the previous group is being taken. Reset clears the stream state
//  and sets max_length to 256000; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module bsmtp_data_deframer_top #(
    parameter int unsigned COUNT_BITS = bsdf_pkg::COUNT_BITS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    bsdf_in_if.sink    stream,
    bsdf_out_if.source result,
    bsdf_cfg_if.sink   cfg
);
    import bsdf_pkg::*;

    logic [LEN_W-1:0] max_length_reg;
    logic             step;
    logic             can_load;
    grp_t             grp;
    res_t             head;
    logic             head_last;

    assign cfg.ready    = 1'b1;
    assign stream.ready = can_load;
    assign step         = stream.valid && can_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= MAX_LEN_RESET;
        end
        else if (cfg.valid)
        begin
            max_length_reg <= cfg.max_length;
        end
    end

    bsdf_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .max_length (max_length_reg),
        .step       (step),
        .data_byte  (stream.data_byte),
        .last_byte  (stream.last_byte),
        .grp        (grp)
    );

    bsdf_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (step),
        .grp_in     (grp),
        .can_load   (can_load),
        .head_valid (result.valid),
        .head_ready (result.ready),
        .head       (head),
        .head_last  (head_last)
    );

    assign result.kind       = head.kind;
    assign result.out_byte   = head.out_byte;
    assign result.region     = head.region;
    assign result.status     = head.status;
    assign result.end_of_run = head_last;

endmodule

`default_nettype wire

// File: hw/rtl/bsdf_checker.sv
// ----------------------------------------------------------------------------
// bsdf_checker
// Port-level checks on the result channel of the deframer.
// ----------------------------------------------------------------------------
`default_nettype none

module bsdf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       valid,
    input logic       ready,
    input logic       kind,
    input logic [7:0] out_byte,
    input logic [1:0] region,
    input logic [1:0] status,
    input logic       end_of_run
);
    import bsdf_pkg::*;

    // A stalled result word holds still.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable({kind, out_byte, region, status, end_of_run}))
        else $error("result word changed while stalled");

    // The status word closes the run of its byte.
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid && kind == KIND_STATUS |-> end_of_run && out_byte == 8'h00)
        else $error("status word not last or carries a byte");

    a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
        valid && kind == KIND_DATA |-> status == ST_OK)
        else $error("data word carries a status");

    // Too big is reported only for a stream that ended oversize, and only then.
    a_too_big: assert property (@(posedge clk) disable iff (!rst_n)
        valid && kind == KIND_STATUS |->
            ((status == ST_TOO_BIG) == (region == PH_OVER)))
        else $error("too-big status and oversize region disagree");

    a_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        valid && kind == KIND_STATUS |->
            ((status == ST_NO_DATA) == (region == PH_ENV)))
        else $error("no-DATA status and envelope region disagree");

endmodule

bind bsmtp_data_deframer_top bsdf_checker u_bsdf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .valid      (result.valid),
    .ready      (result.ready),
    .kind       (result.kind),
    .out_byte   (result.out_byte),
    .region     (result.region),
    .status     (result.status),
    .end_of_run (result.end_of_run)
);

`default_nettype wire
